// ===== design/irc_pkg.sv =====
// shared types and constants of the imu record crc checker
`default_nettype none

package irc_pkg;

  // record geometry
  localparam int MAX_RECORD_BYTES = 64;
  localparam int MIN_RECORD_BYTES = 8;
  localparam int MAX_SWAPPED_WORDS = 16;

  // crc-32/mpeg-2
  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] CFG_RECORD_LENGTH = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_HEADER_WORD   = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_SWAPPED_WORDS = 2'd2;

  // reset values of the configuration registers
  localparam logic [6:0]  RST_RECORD_LENGTH = 7'd36;
  localparam logic [31:0] RST_HEADER_WORD   = 32'd1442808318;
  localparam logic [4:0]  RST_SWAPPED_WORDS = 5'd7;

  // result queue between the byte front end and the result back end
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_WORD    = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_CRC_ERR = 3'd2,
    KIND_HDR_BAD = 3'd3,
    KIND_SHORT   = 3'd4
  } kind_t;

  // everything one byte produces: an optional word, then an optional verdict
  typedef struct packed {
    logic        has_word;
    logic [31:0] word_value;
    logic [3:0]  word_index;
    logic        has_verdict;
    kind_t       verdict;
    logic [31:0] good_records;
    logic [15:0] crc_errors;
    logic [7:0]  uart_error_bits;
  } rec_desc_t;

endpackage

`default_nettype wire

// ===== design/irc_front.sv =====
// byte front end: record framing, crc, header check, counters and config registers
`default_nettype none

module irc_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_valid,
  input  wire logic [irc_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [31:0]              cfg_data,
  input  wire logic                     byte_take,
  input  wire logic [7:0]               data_byte,
  input  wire logic                     first_byte,
  input  wire logic [7:0]               uart_error,
  input  wire logic                     clear_counts,
  output logic                          push,
  output irc_pkg::rec_desc_t            push_data
);
  import irc_pkg::*;

  // bytewise crc update, msb first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {b, 24'd0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
    end
    return c;
  endfunction

  logic [6:0]  record_length_r;
  logic [31:0] header_word_r;
  logic [4:0]  swapped_words_r;

  logic [6:0]  pos_r, pos_nxt;
  logic        in_rec_r, in_rec_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [23:0] shift_r, shift_nxt;
  logic        hbad_r, hbad_nxt;
  logic [31:0] good_r, good_nxt;
  logic [15:0] fail_r, fail_nxt;
  logic [7:0]  sticky_r, sticky_nxt;

  logic [6:0]  len;
  logic [4:0]  nwords;
  logic        open_rec, short_drop, at_end, hdr_miss, word_hit;
  logic [6:0]  pos_eff;
  logic [31:0] crc_eff, crc_upd;
  logic [23:0] shift_eff;
  logic        hbad_eff, hbad_upd;
  logic [15:0] fail_base;
  kind_t       verdict;

  always_comb begin
    // saturate configuration to its legal range
    if (record_length_r < 7'(MIN_RECORD_BYTES)) len = 7'(MIN_RECORD_BYTES);
    else if (record_length_r > 7'(MAX_RECORD_BYTES)) len = 7'(MAX_RECORD_BYTES);
    else len = record_length_r;
    nwords = (swapped_words_r > 5'(MAX_SWAPPED_WORDS)) ? 5'(MAX_SWAPPED_WORDS)
                                                        : swapped_words_r;

    fail_base  = clear_counts ? 16'd0 : fail_r;
    sticky_nxt = (clear_counts ? 8'd0 : sticky_r) | uart_error;

    // a start marker restarts the record state
    short_drop = first_byte & in_rec_r;
    open_rec   = first_byte | in_rec_r;
    pos_eff    = first_byte ? 7'd0 : pos_r;
    crc_eff    = first_byte ? CRC_INIT : crc_r;
    shift_eff  = first_byte ? 24'd0 : shift_r;
    hbad_eff   = first_byte ? 1'b0 : hbad_r;

    crc_upd  = crc_byte(crc_eff, data_byte);
    hdr_miss = (pos_eff[6:2] == 5'd0) && (data_byte != header_word_r[8*pos_eff[1:0] +: 8]);
    hbad_upd = hbad_eff | hdr_miss;
    word_hit = open_rec && (pos_eff[1:0] == 2'd3) && (pos_eff[6:2] < nwords);
    at_end   = open_rec && ({1'b0, pos_eff} + 8'd1 >= {1'b0, len});

    in_rec_nxt = open_rec;
    pos_nxt    = pos_eff;
    crc_nxt    = crc_eff;
    shift_nxt  = shift_eff;
    hbad_nxt   = hbad_eff;
    good_nxt   = good_r;
    fail_nxt   = fail_base;
    verdict    = KIND_SHORT;

    if (open_rec) begin
      crc_nxt   = crc_upd;
      shift_nxt = {shift_eff[15:0], data_byte};
      hbad_nxt  = hbad_upd;
      if (at_end) begin
        in_rec_nxt = 1'b0;
        pos_nxt    = 7'd0;
        if (hbad_upd) begin
          verdict = KIND_HDR_BAD;
        end else if (crc_upd == 32'd0) begin
          verdict  = KIND_GOOD;
          good_nxt = good_r + 32'd1;
        end else begin
          verdict = KIND_CRC_ERR;
          if (fail_base != 16'hFFFF) fail_nxt = fail_base + 16'd1;
        end
      end else begin
        pos_nxt = pos_eff + 7'd1;
      end
    end

    push_data.has_word        = word_hit;
    push_data.word_value      = {shift_eff, data_byte};
    push_data.word_index      = pos_eff[5:2];
    push_data.has_verdict     = short_drop | at_end;
    push_data.verdict         = short_drop ? KIND_SHORT : verdict;
    push_data.good_records    = good_nxt;
    push_data.crc_errors      = fail_nxt;
    push_data.uart_error_bits = sticky_nxt;
    push = byte_take & (word_hit | short_drop | at_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_length_r <= RST_RECORD_LENGTH;
      header_word_r   <= RST_HEADER_WORD;
      swapped_words_r <= RST_SWAPPED_WORDS;
      pos_r    <= 7'd0;
      in_rec_r <= 1'b0;
      crc_r    <= CRC_INIT;
      shift_r  <= 24'd0;
      hbad_r   <= 1'b0;
      good_r   <= 32'd0;
      fail_r   <= 16'd0;
      sticky_r <= 8'd0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_RECORD_LENGTH: record_length_r <= cfg_data[6:0];
          CFG_HEADER_WORD:   header_word_r   <= cfg_data;
          CFG_SWAPPED_WORDS: swapped_words_r <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (byte_take) begin
        pos_r    <= pos_nxt;
        in_rec_r <= in_rec_nxt;
        crc_r    <= crc_nxt;
        shift_r  <= shift_nxt;
        hbad_r   <= hbad_nxt;
        good_r   <= good_nxt;
        fail_r   <= fail_nxt;
        sticky_r <= sticky_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/irc_queue.sv =====
// small fifo of per-byte result descriptors
`default_nettype none

module irc_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  irc_pkg::rec_desc_t      push_data,
  output logic                    full,
  input  wire logic               pop,
  output irc_pkg::rec_desc_t      pop_data,
  output logic                    empty
);
  import irc_pkg::*;

  rec_desc_t            slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CW-1:0]  count_r;

  assign full     = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  // pointers wrap on their own since the depth is a power of two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/irc_back.sv =====
// result back end: splits each descriptor into its word and verdict beats
`default_nettype none

module irc_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  irc_pkg::rec_desc_t      pop_data,
  input  wire logic               empty,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_kind,
  output logic [31:0]             out_word_value,
  output logic [3:0]              out_word_index,
  output logic [31:0]             out_good_records,
  output logic [15:0]             out_crc_errors,
  output logic [7:0]              out_uart_error_bits,
  output logic                    out_last
);
  import irc_pkg::*;

  rec_desc_t cur_r;
  logic      cur_valid_r;
  logic      phase_r;
  logic      take, word_beat, more;

  assign take      = cur_valid_r & ~out_stall;
  assign word_beat = ~phase_r & cur_r.has_word;
  // a word beat with a verdict behind it
  assign more      = word_beat & cur_r.has_verdict;
  assign pop       = ~empty & (~cur_valid_r | (take & ~more));

  assign out_valid           = cur_valid_r;
  assign out_kind            = word_beat ? KIND_WORD : cur_r.verdict;
  assign out_word_value      = word_beat ? cur_r.word_value : 32'd0;
  assign out_word_index      = word_beat ? cur_r.word_index : 4'd0;
  assign out_good_records    = cur_r.good_records;
  assign out_crc_errors      = cur_r.crc_errors;
  assign out_uart_error_bits = cur_r.uart_error_bits;
  assign out_last            = ~more;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else if (pop) begin
      cur_r       <= pop_data;
      cur_valid_r <= 1'b1;
      phase_r     <= 1'b0;
    end else if (take) begin
      if (more) phase_r <= 1'b1;
      else cur_valid_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== design/imu_record_crc_checker.sv =====
// top level of the imu record crc checker
`default_nettype none

// Checks a framed byte stream of fixed-length sensor records. Each record's
// first four bytes (little-endian) are compared with header_word, and
// CRC-32/MPEG-2 runs over all bytes including the trailing crc; a zero residue
// passes. The leading swapped_words words leave as big-endian word beats, and
// the last byte of a record gives one verdict beat: good, crc error or header
// mismatch; a new start marker that cuts a record off gives short dropped. Every
// beat carries the counters as they stand after its byte. The block takes one
// byte per clock unless in_stall, which rises only while the queue is full; the
// front end does the crc update, header check and counters in that cycle and
// writes at most one descriptor into a four-entry queue. While out_stall is low
// the back end sends one beat per clock, a byte's word beat before its verdict.
// Configuration writes are always ready and must come while the block is idle.
`default_nettype none

module imu_record_crc_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // configuration write channel
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [irc_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [31:0]                cfg_data,
  // byte input channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [7:0]                 in_data_byte,
  input  wire logic                       in_first_byte,
  input  wire logic [7:0]                 in_uart_error,
  input  wire logic                       in_clear_counts,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [2:0]                      out_kind,
  output logic [31:0]                     out_word_value,
  output logic [3:0]                      out_word_index,
  output logic [31:0]                     out_good_records,
  output logic [15:0]                     out_crc_errors,
  output logic [7:0]                      out_uart_error_bits,
  output logic                            out_last
);
  import irc_pkg::*;

  rec_desc_t push_data, pop_data;
  logic      push, pop, full, empty, byte_take;

  // registers never refuse a write
  assign cfg_ready = 1'b1;
  // stall comes straight from the registered queue fill level
  assign in_stall  = full;
  assign byte_take = in_valid & ~full;

  irc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .byte_take    (byte_take),
    .data_byte    (in_data_byte),
    .first_byte   (in_first_byte),
    .uart_error   (in_uart_error),
    .clear_counts (in_clear_counts),
    .push         (push),
    .push_data    (push_data)
  );

  // descriptors with no result never enter the queue
  irc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  irc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .pop_data            (pop_data),
    .empty               (empty),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_word_value      (out_word_value),
    .out_word_index      (out_word_index),
    .out_good_records    (out_good_records),
    .out_crc_errors      (out_crc_errors),
    .out_uart_error_bits (out_uart_error_bits),
    .out_last            (out_last)
  );

endmodule

`default_nettype wire

// ===== bench/irc_scoreboard_pkg.sv =====
// record predictor and result scoreboard for the imu record crc checker bench
package irc_scoreboard_pkg;
  import irc_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] word_value;
    logic [3:0]  word_index;
    logic [31:0] good_records;
    logic [15:0] crc_errors;
    logic [7:0]  uart_error_bits;
    logic        last;
  } beat_t;

  // one byte of crc-32/mpeg-2, msb first
  function automatic logic [31:0] crc32_mpeg2_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h0};
    for (int i = 0; i < 8; i++)
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  class irc_scoreboard;
    logic [6:0]  record_length;
    logic [31:0] header_word;
    logic [4:0]  swapped_words;

    logic [6:0]  byte_pos;
    bit          rec_open;
    logic [31:0] crc;
    logic [23:0] shift_bytes;
    bit          header_bad;
    logic [31:0] good_count;
    logic [15:0] crc_fail_count;
    logic [7:0]  uart_sticky;

    beat_t       due_beats[$];
    int unsigned errors;

    function new();
      record_length  = RST_RECORD_LENGTH;
      header_word    = RST_HEADER_WORD;
      swapped_words  = RST_SWAPPED_WORDS;
      byte_pos       = '0;
      rec_open       = 1'b0;
      crc            = CRC_INIT;
      shift_bytes    = '0;
      header_bad     = 1'b0;
      good_count     = '0;
      crc_fail_count = '0;
      uart_sticky    = '0;
      errors         = 0;
    endfunction

    function void write_reg(input logic [CFG_IW-1:0] idx, input logic [31:0] data);
      case (idx)
        CFG_RECORD_LENGTH: record_length = data[6:0];
        CFG_HEADER_WORD:   header_word = data;
        CFG_SWAPPED_WORDS: swapped_words = data[4:0];
        default: ;
      endcase
    endfunction

    // record length as the block uses it
    function int unsigned record_bytes();
      if (record_length < MIN_RECORD_BYTES) return MIN_RECORD_BYTES;
      if (record_length > MAX_RECORD_BYTES) return MAX_RECORD_BYTES;
      return record_length;
    endfunction

    function beat_t beat_of(input kind_t k, input logic [31:0] v, input logic [3:0] i);
      beat_t b;
      b.kind = k;
      b.word_value = v;
      b.word_index = i;
      b.good_records = '0;
      b.crc_errors = '0;
      b.uart_error_bits = '0;
      b.last = 1'b0;
      return b;
    endfunction

    function void note_byte(input logic [7:0] data, input bit first, input logic [7:0] uerr,
                            input bit clr);
      beat_t made[$];
      int unsigned len, nwords, pos;
      len = record_bytes();
      nwords = (swapped_words > MAX_SWAPPED_WORDS) ? MAX_SWAPPED_WORDS : swapped_words;
      if (clr) begin
        crc_fail_count = '0;
        uart_sticky = '0;
      end
      uart_sticky |= uerr;
      if (first) begin
        if (rec_open) made.push_back(beat_of(KIND_SHORT, '0, '0));
        rec_open = 1'b1;
        byte_pos = '0;
        crc = CRC_INIT;
        shift_bytes = '0;
        header_bad = 1'b0;
      end
      if (rec_open) begin
        pos = byte_pos;
        crc = crc32_mpeg2_step(crc, data);
        if (pos < 4 && data != header_word[8*pos +: 8]) header_bad = 1'b1;
        if (pos[1:0] == 2'd3 && (pos >> 2) < nwords)
          made.push_back(beat_of(KIND_WORD, {shift_bytes, data}, 4'(pos >> 2)));
        shift_bytes = {shift_bytes[15:0], data};
        if (pos + 1 >= len) begin
          if (header_bad) begin
            made.push_back(beat_of(KIND_HDR_BAD, '0, '0));
          end else if (crc == '0) begin
            good_count++;
            made.push_back(beat_of(KIND_GOOD, '0, '0));
          end else begin
            if (crc_fail_count != 16'hFFFF) crc_fail_count++;
            made.push_back(beat_of(KIND_CRC_ERR, '0, '0));
          end
          rec_open = 1'b0;
          byte_pos = '0;
        end else begin
          byte_pos = 7'(pos + 1);
        end
      end
      foreach (made[k]) begin
        made[k].good_records = good_count;
        made[k].crc_errors = crc_fail_count;
        made[k].uart_error_bits = uart_sticky;
        made[k].last = (k == made.size() - 1);
        due_beats.push_back(made[k]);
      end
    endfunction

    function void compare_field(input string name, input logic [31:0] want_v,
                                input logic [31:0] got_v);
      if (got_v !== want_v) begin
        $error("%s expected 0x%0h got 0x%0h", name, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_beat(input beat_t got);
      beat_t want;
      if (due_beats.size() == 0) begin
        $error("result beat with nothing due, kind %0d", got.kind);
        errors++;
        return;
      end
      want = due_beats.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("word_value", want.word_value, got.word_value);
      compare_field("word_index", want.word_index, got.word_index);
      compare_field("good_records", want.good_records, got.good_records);
      compare_field("crc_errors", want.crc_errors, got.crc_errors);
      compare_field("uart_error_bits", want.uart_error_bits, got.uart_error_bits);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

endpackage

// ===== bench/imu_record_crc_checker_tb.sv =====
// top level bench: drives framed records into the crc checker and checks every result beat
module imu_record_crc_checker_tb;
  import irc_pkg::*;
  import irc_scoreboard_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [31:0]       cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_data_byte;
  logic              in_first_byte;
  logic [7:0]        in_uart_error;
  logic              in_clear_counts;
  logic              out_valid;
  logic              out_stall;
  logic [2:0]        out_kind;
  logic [31:0]       out_word_value;
  logic [3:0]        out_word_index;
  logic [31:0]       out_good_records;
  logic [15:0]       out_crc_errors;
  logic [7:0]        out_uart_error_bits;
  logic              out_last;

  // idling controls: calm flags switch off random gaps, hold_req asks the sink for a long stall
  bit                src_calm;
  bit                sink_calm;
  int unsigned       hold_req;
  // bytes sent as part of framed records, used to size the traffic phases
  int unsigned       record_bytes_sent;

  irc_scoreboard sb = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  imu_record_crc_checker dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_first_byte      (in_first_byte),
    .in_uart_error      (in_uart_error),
    .in_clear_counts    (in_clear_counts),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_word_value     (out_word_value),
    .out_word_index     (out_word_index),
    .out_good_records   (out_good_records),
    .out_crc_errors     (out_crc_errors),
    .out_uart_error_bits(out_uart_error_bits),
    .out_last           (out_last)
  );

  // result sink: random stalls, or a counted hold-off when one is requested
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !sink_calm && ($urandom_range(99) < 16);
      end
    end
  end

  // every accepted result beat goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_beat(beat_t'{kind: kind_t'(out_kind), word_value: out_word_value,
                            word_index: out_word_index, good_records: out_good_records,
                            crc_errors: out_crc_errors, uart_error_bits: out_uart_error_bits,
                            last: out_last});
  end

  // one input beat; called at a falling edge, returns at a falling edge with valid still up
  task automatic send_byte(input logic [7:0] data, input bit first, input logic [7:0] uerr,
                           input bit clr);
    while (!src_calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= data;
    in_first_byte   <= first;
    in_uart_error   <= uerr;
    in_clear_counts <= clr;
    do @(posedge clk); while (in_stall);
    sb.note_byte(data, first, uerr, clr);
    @(negedge clk);
  endtask

  // drop valid, wait for every owed beat, then let the pipeline settle
  task automatic drain(input int unsigned tail);
    in_valid <= 1'b0;
    while (sb.due_beats.size() != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  // writes all three registers back to back once the block is idle
  task automatic set_config(input logic [31:0] len, input logic [31:0] hdr,
                            input logic [31:0] nw);
    logic [CFG_IW-1:0] regs [3];
    logic [31:0]       vals [3];
    regs = '{CFG_RECORD_LENGTH, CFG_HEADER_WORD, CFG_SWAPPED_WORDS};
    vals = '{len, hdr, nw};
    drain(16);
    for (int r = 0; r < 3; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[r];
      cfg_data  <= vals[r];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(regs[r], vals[r]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // one framed record: header from the register, random body, crc appended msb first
  // so the residue comes out zero; optional header or crc damage, optional cut
  task automatic send_record(input int unsigned cut, input bit bad_hdr, input bit bad_crc,
                             input int unsigned noise_pct, input logic [7:0] lead_err,
                             input bit lead_clr);
    logic [7:0]  rec [MAX_RECORD_BYTES];
    logic [31:0] crc;
    logic [7:0]  uerr;
    bit          clr;
    int unsigned len, spot;
    len = sb.record_bytes();
    for (int i = 0; i < 4; i++) rec[i] = sb.header_word[8*i +: 8];
    if (bad_hdr) begin
      spot = $urandom_range(3);
      rec[spot] ^= 8'(1 << $urandom_range(7));
    end
    for (int i = 4; i < len - 4; i++) rec[i] = 8'($urandom);
    crc = CRC_INIT;
    for (int i = 0; i < len - 4; i++) crc = crc32_mpeg2_step(crc, rec[i]);
    for (int i = 0; i < 4; i++) rec[len - 4 + i] = crc[31 - 8*i -: 8];
    // a single flipped bit past the header always breaks the residue
    if (bad_crc) begin
      spot = $urandom_range(len - 1, 4);
      rec[spot] ^= 8'(1 << $urandom_range(7));
    end
    if (cut > len) cut = len;
    for (int i = 0; i < cut; i++) begin
      uerr = ($urandom_range(99) < noise_pct) ? 8'($urandom) : 8'h00;
      clr = (noise_pct != 0) && ($urandom_range(59) == 0);
      if (i == 0) begin
        uerr |= lead_err;
        clr |= lead_clr;
      end
      send_byte(rec[i], i == 0, uerr, clr);
    end
    record_bytes_sent += cut;
  endtask

  // mostly clean records with random content, plus damaged, cut and stray traffic
  task automatic mixed_traffic(input int unsigned quota);
    int unsigned start, pick, len;
    start = record_bytes_sent;
    while (record_bytes_sent - start < quota) begin
      pick = $urandom_range(99);
      len = sb.record_bytes();
      if (pick < 68) begin
        send_record(len, 1'b0, 1'b0, 12, 8'h00, 1'b0);
      end else if (pick < 78) begin
        send_record(len, 1'b0, 1'b1, 12, 8'h00, 1'b0);
      end else if (pick < 86) begin
        send_record(len, 1'b1, 1'($urandom_range(1)), 12, 8'h00, 1'b0);
      end else if (pick < 94) begin
        send_record($urandom_range(len - 1, 1), 1'($urandom_range(1)), 1'b0, 12, 8'h00, 1'b0);
      end else begin
        // unframed bytes: dropped when no record is open, else they continue a cut one
        repeat ($urandom_range(3, 1))
          send_byte(8'($urandom), 1'b0, 8'($urandom), $urandom_range(15) == 0);
      end
    end
    // close the phase on a complete record so the next config write sees no open record
    send_record(sb.record_bytes(), 1'b0, 1'b0, 12, 8'h00, 1'b0);
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_index         = CFG_RECORD_LENGTH;
    cfg_data          = '0;
    in_valid          = 1'b0;
    in_data_byte      = '0;
    in_first_byte     = 1'b0;
    in_uart_error     = '0;
    in_clear_counts   = 1'b0;
    src_calm          = 1'b0;
    sink_calm         = 1'b0;
    hold_req          = 0;
    record_bytes_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: shortest records, header bytes at 0xff and 0x00, every verdict
    set_config(8, 32'h00FF_00FF, 16);
    // stray byte with no record open, its error bits still land in the sticky bits
    send_byte(8'hFF, 1'b0, 8'hFF, 1'b0);
    // clear and error on the same byte; second word and good verdict share the last byte
    send_record(8, 1'b0, 1'b0, 0, 8'h01, 1'b1);
    send_record(8, 1'b1, 1'b0, 0, 8'hFF, 1'b0);
    // cut record, then a new start inside it gives short dropped before the crc error
    send_record(3, 1'b0, 1'b0, 0, 8'h80, 1'b0);
    send_record(8, 1'b0, 1'b1, 0, 8'h00, 1'b0);

    // back to back crc errors with no idling on either side
    set_config(8, $urandom, 0);
    src_calm = 1'b1;
    sink_calm = 1'b1;
    repeat (12) send_record(8, 1'b0, 1'b1, 0, 8'h00, 1'b0);
    send_record(8, 1'b0, 1'b1, 0, 8'h00, 1'b1);
    src_calm = 1'b0;
    sink_calm = 1'b0;

    // random phases; lengths and word counts beyond range get clamped by the block
    set_config(0, 32'h0000_0000, 31);
    mixed_traffic(220);
    set_config(127, 32'hFFFF_FFFF, 17);
    // long sink hold-off while bytes keep coming, fills the result queue
    hold_req = 300;
    mixed_traffic(220);
    set_config(64, $urandom, 0);
    mixed_traffic(220);
    set_config(13, $urandom, 3);
    mixed_traffic(220);
    repeat (2) begin
      set_config($urandom_range(64, 8), $urandom, $urandom_range(31));
      mixed_traffic(220);
    end

    drain(20);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
design/irc_pkg.sv
design/irc_front.sv
design/irc_queue.sv
design/irc_back.sv
design/imu_record_crc_checker.sv
bench/irc_scoreboard_pkg.sv
bench/imu_record_crc_checker_tb.sv
